>>> hw/rtl/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared constants and types for the RV64I subset decoder with label table.
// ----------------------------------------------------------------------------
`default_nettype none

package rvdec_pkg;

    localparam int LabelDepth = 64;
    localparam int LineBits   = 16;
    localparam int AddrBits   = (LabelDepth > 1) ? $clog2(LabelDepth) : 1;
    localparam int CntBits    = $clog2(LabelDepth + 1);
    localparam int TgtBits    = 20;
    localparam int LblBits    = 7;

    // format codes
    localparam logic [2:0] FMT_R = 3'd0;
    localparam logic [2:0] FMT_I = 3'd1;
    localparam logic [2:0] FMT_S = 3'd2;
    localparam logic [2:0] FMT_B = 3'd3;
    localparam logic [2:0] FMT_U = 3'd4;
    localparam logic [2:0] FMT_J = 3'd5;

    // opcodes
    localparam logic [6:0] OP_REG  = 7'b0110011;
    localparam logic [6:0] OP_BR   = 7'b1100011;
    localparam logic [6:0] OP_JAL  = 7'b1101111;
    localparam logic [6:0] OP_IMM  = 7'b0010011;
    localparam logic [6:0] OP_LOAD = 7'b0000011;
    localparam logic [6:0] OP_JALR = 7'b1100111;
    localparam logic [6:0] OP_STO  = 7'b0100011;
    localparam logic [6:0] OP_LUI  = 7'b0110111;

    // selected mnemonic codes
    localparam logic [5:0] MN_ADD  = 6'd0;
    localparam logic [5:0] MN_SUB  = 6'd1;
    localparam logic [5:0] MN_SLL  = 6'd2;
    localparam logic [5:0] MN_XOR  = 6'd3;
    localparam logic [5:0] MN_SRL  = 6'd4;
    localparam logic [5:0] MN_SRA  = 6'd5;
    localparam logic [5:0] MN_OR   = 6'd6;
    localparam logic [5:0] MN_AND  = 6'd7;
    localparam logic [5:0] MN_JAL  = 6'd8;
    localparam logic [5:0] MN_SB   = 6'd9;
    localparam logic [5:0] MN_BEQ  = 6'd13;
    localparam logic [5:0] MN_LUI  = 6'd19;
    localparam logic [5:0] MN_ADDI = 6'd20;
    localparam logic [5:0] MN_SLLI = 6'd21;
    localparam logic [5:0] MN_XORI = 6'd22;
    localparam logic [5:0] MN_SRLI = 6'd23;
    localparam logic [5:0] MN_SRAI = 6'd24;
    localparam logic [5:0] MN_ORI  = 6'd25;
    localparam logic [5:0] MN_ANDI = 6'd26;
    localparam logic [5:0] MN_LB   = 6'd27;
    localparam logic [5:0] MN_JALR = 6'd34;

    typedef struct packed {
        logic        ok;
        logic [2:0]  fmt;
        logic [5:0]  mn;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [20:0] imm;
    } t_dec;

    // Combinational decode of one instruction word
    function automatic t_dec decode(input logic [31:0] w);
        t_dec       d;
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [5:0] top6;
        op   = w[6:0];
        f3   = w[14:12];
        f7   = w[31:25];
        top6 = w[31:26];
        d    = '0;
        d.ok = 1'b1;
        case (op)
            OP_REG: begin
                d.fmt = FMT_R;
                if (f7 == 7'd0) begin
                    case (f3)
                        3'd0: d.mn = MN_ADD;
                        3'd1: d.mn = MN_SLL;
                        3'd4: d.mn = MN_XOR;
                        3'd5: d.mn = MN_SRL;
                        3'd6: d.mn = MN_OR;
                        3'd7: d.mn = MN_AND;
                        default: d.ok = 1'b0;
                    endcase
                end else if (f7 == 7'd32 && f3 == 3'd0) begin
                    d.mn = MN_SUB;
                end else if (f7 == 7'd32 && f3 == 3'd5) begin
                    d.mn = MN_SRA;
                end else begin
                    d.ok = 1'b0;
                end
            end
            OP_JAL: begin
                d.fmt = FMT_J;
                d.mn  = MN_JAL;
            end
            OP_LUI: begin
                d.fmt = FMT_U;
                d.mn  = MN_LUI;
            end
            OP_STO: begin
                d.fmt = FMT_S;
                d.ok  = !f3[2];
                d.mn  = MN_SB + {3'd0, f3};
            end
            OP_BR: begin
                d.fmt = FMT_B;
                d.ok  = (f3 != 3'd2) && (f3 != 3'd3);
                d.mn  = f3[2] ? (MN_BEQ + {3'd0, f3} - 6'd2) : (MN_BEQ + {3'd0, f3});
            end
            OP_IMM: begin
                d.fmt = FMT_I;
                case (f3)
                    3'd0: d.mn = MN_ADDI;
                    3'd1: begin
                        d.mn = MN_SLLI;
                        d.ok = (top6 == 6'd0);
                    end
                    3'd4: d.mn = MN_XORI;
                    3'd5: begin
                        d.mn = (top6 == 6'd16) ? MN_SRAI : MN_SRLI;
                        d.ok = (top6 == 6'd0) || (top6 == 6'd16);
                    end
                    3'd6: d.mn = MN_ORI;
                    3'd7: d.mn = MN_ANDI;
                    default: d.ok = 1'b0;
                endcase
            end
            OP_LOAD: begin
                d.fmt = FMT_I;
                d.ok  = (f3 != 3'd7);
                d.mn  = MN_LB + {3'd0, f3};
            end
            OP_JALR: begin
                d.fmt = FMT_I;
                d.mn  = MN_JALR;
                d.ok  = (f3 == 3'd0);
            end
            default: d.ok = 1'b0;
        endcase

        // register fields by format
        d.rd  = (d.fmt == FMT_B || d.fmt == FMT_S) ? 5'd0 : w[11:7];
        d.rs1 = (d.fmt == FMT_U || d.fmt == FMT_J) ? 5'd0 : w[19:15];
        d.rs2 = (d.fmt == FMT_R || d.fmt == FMT_S || d.fmt == FMT_B) ? w[24:20] : 5'd0;

        // immediate by format
        case (d.fmt)
            FMT_I: begin
                if (d.mn == MN_SLLI || d.mn == MN_SRLI || d.mn == MN_SRAI)
                    d.imm = {15'd0, w[25:20]};
                else
                    d.imm = {{9{w[31]}}, w[31:20]};
            end
            FMT_U: d.imm = {1'b0, w[31:12]};
            FMT_S: d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
            FMT_B: d.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FMT_J: d.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: d.imm = '0;
        endcase

        if (!d.ok)
            d = '0;
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rv64i_subset_decoder_with_labels_unit.sv
// ----------------------------------------------------------------------------
// rv64i_subset_decoder_with_labels_unit
// Decodes RV64I subset words and numbers branch and jump target lines.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*) carries one 32-bit instruction word per transfer.
//   Master stream (m_axis_*) carries one decoded result per input word.
//   Words that are not branches or jal go through ST_DONE: m_axis_tvalid rises
//   in the cycle after the accepting edge, and the next word is taken in ST_IDLE.
//   Branches and jal scan the label memory, one stored target per cycle,
//   through its single synchronous read port, after a priming read; a hit
//   ends the scan early. With N labels stored (at most 64), at most N targets
//   are compared; the result is loaded at the end of ST_SCAN, m_axis_tvalid
//   is set in ST_DONE, and the next word is taken back in ST_IDLE.
//   One word is in flight at a time; a new word is accepted only when the
//   output register is empty or its result is taken in the same cycle.
//   Reset clears the line counter and the label count; the label memory
//   itself is not cleared, entries at or above the count are never compared.
//   When the receiver stalls, the result holds in the output register and
//   the block stops taking input until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64i_subset_decoder_with_labels_unit
    import rvdec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] instr_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata    // ok, format_code, mnemonic_code,
                                             // dest_reg, src1_reg, src2_reg,
                                             // immediate, line_index, has_label,
                                             // label_number, target_line,
                                             // table_full; zero padded
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state;
    t_dec                r_dec;
    logic [LineBits-1:0] r_line;
    logic [TgtBits-1:0]  r_tgt;
    logic [CntBits-1:0]  r_cnt;
    logic [CntBits-1:0]  r_idx;       // entry whose data arrives this cycle
    logic                r_rd_vld;
    logic [TgtBits-1:0]  r_mem [LabelDepth];
    logic [TgtBits-1:0]  r_rdata;
    logic                r_out_vld;
    logic [95:0]         r_out;

    t_dec                w_dec;
    logic [LineBits-1:0] w_line;
    logic                w_lbl;
    logic [TgtBits-1:0]  w_tgt;
    logic [20:0]         w_q;
    logic                w_out_free;
    logic                w_hit;
    logic                w_end;
    logic [LblBits-1:0]  w_lnum;
    logic                w_full;
    logic                w_wr;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;

    // decode and target line in the accept cycle
    always_comb begin
        w_dec  = decode(s_axis_tdata);
        w_line = r_line + LineBits'(1);
        w_lbl  = w_dec.ok && (w_dec.fmt == FMT_B || w_dec.fmt == FMT_J);
        // divide by four truncating toward zero
        w_q    = $signed(w_dec.imm) >>> 2;
        if (w_dec.imm[20] && (w_dec.imm[1:0] != 2'd0))
            w_q = w_q + 21'd1;
        w_tgt  = TgtBits'({{(32-LineBits){1'b0}}, w_line} + {{11{w_q[20]}}, w_q});
    end

    // scan compare on registered memory data
    always_comb begin
        w_hit  = (r_state == ST_SCAN) && r_rd_vld && (r_rdata == r_tgt);
        w_end  = (r_state == ST_SCAN) && (w_hit || (r_idx >= r_cnt && !r_rd_vld)
                 || (r_rd_vld && r_idx + CntBits'(1) >= r_cnt && !w_hit));
        w_full = 1'b0;
        w_wr   = 1'b0;
        w_lnum = '0;
        if (w_hit) begin
            w_lnum = LblBits'(r_idx) + LblBits'(1);
        end else if (w_end) begin
            if (r_cnt == CntBits'(LabelDepth)) begin
                w_full = 1'b1;
            end else begin
                w_wr   = 1'b1;
                w_lnum = LblBits'(r_cnt) + LblBits'(1);
            end
        end
    end

    // label memory: one synchronous read, one write
    always_ff @(posedge i_clk) begin
        if (w_wr)
            r_mem[r_cnt[AddrBits-1:0]] <= r_tgt;
        r_rdata <= r_mem[r_idx[AddrBits-1:0] + ((r_rd_vld) ? AddrBits'(1) : AddrBits'(0))];
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_line    <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && m_axis_tready)
                r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_dec <= w_dec;
                        r_tgt <= w_tgt;
                        r_idx <= '0;
                        r_rd_vld <= 1'b0;
                        if (w_dec.ok)
                            r_line <= w_line;
                        r_state <= w_lbl ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (w_end) begin
                        if (w_wr)
                            r_cnt <= r_cnt + CntBits'(1);
                        r_out <= {5'd0, w_full, r_tgt, w_lnum, 1'b1, r_line,
                                  r_dec.imm, r_dec.rs2, r_dec.rs1, r_dec.rd,
                                  r_dec.mn, r_dec.fmt, r_dec.ok};
                        r_rd_vld <= 1'b0;
                        r_state  <= ST_DONE;
                    end else begin
                        if (r_rd_vld)
                            r_idx <= r_idx + CntBits'(1);
                        r_rd_vld <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_dec.fmt != FMT_B && r_dec.fmt != FMT_J || !r_dec.ok)
                            r_out <= {5'd0, 1'b0, {TgtBits{1'b0}}, {LblBits{1'b0}},
                                      1'b0, r_dec.ok ? r_line : {LineBits{1'b0}},
                                      r_dec.imm, r_dec.rs2, r_dec.rs1, r_dec.rd,
                                      r_dec.mn, r_dec.fmt, r_dec.ok};
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // assertions
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntBits'(LabelDepth)) else $error("label count overflow");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> (r_cnt == $past(r_cnt) + CntBits'(1)))
        else $error("label count jumped");

endmodule

`default_nettype wire
